// ===== rtl/i2cms_pkg.sv =====
`timescale 1ns / 1ps
package i2cms_pkg;

   typedef enum logic [2:0] {
      CMD_START      = 3'd0,
      CMD_STOP       = 3'd1,
      CMD_WRITE_BYTE = 3'd2,
      CMD_READ_BYTE  = 3'd3,
      CMD_SEND_ACK   = 3'd4,
      CMD_READ_ACK   = 3'd5
   } cmd_type;

   localparam logic [7:0] MSB_MASK = 8'h80;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
   } desc_type;

   typedef struct packed {
      logic       valid;
      desc_type   desc;
   } cq_head_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] value;
      logic       last;
   } result_type;

endpackage

// ===== rtl/i2cms_front.sv =====
`timescale 1ns / 1ps
module i2cms_front (
   input  logic [2:0]          command,
   input  logic [7:0]          data_byte,
   input  logic                ack_bit,
   input  logic [7:0]          line_bits,
   output logic                desc_valid,
   output i2cms_pkg::desc_type desc
);

   // data holds the bits the back end shifts out or reports
   always_comb begin
      desc_valid = 1'b1;
      desc.cmd   = i2cms_pkg::CMD_START;
      desc.data  = 8'h00;
      unique case (command)
         i2cms_pkg::CMD_START: begin
            desc.cmd = i2cms_pkg::CMD_START;
         end
         i2cms_pkg::CMD_STOP: begin
            desc.cmd = i2cms_pkg::CMD_STOP;
         end
         i2cms_pkg::CMD_WRITE_BYTE: begin
            desc.cmd  = i2cms_pkg::CMD_WRITE_BYTE;
            desc.data = data_byte;
         end
         i2cms_pkg::CMD_READ_BYTE: begin
            desc.cmd  = i2cms_pkg::CMD_READ_BYTE;
            desc.data = line_bits;
         end
         i2cms_pkg::CMD_SEND_ACK: begin
            desc.cmd  = i2cms_pkg::CMD_SEND_ACK;
            desc.data = {ack_bit, 7'b0};
         end
         i2cms_pkg::CMD_READ_ACK: begin
            desc.cmd  = i2cms_pkg::CMD_READ_ACK;
            desc.data = {7'b0, |(line_bits & i2cms_pkg::MSB_MASK)};
         end
         default: begin
            desc_valid = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/i2cms_cmd_queue.sv =====
`timescale 1ns / 1ps
module i2cms_cmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  i2cms_pkg::desc_type    push_desc,
   output logic                   full,
   input  logic                   pop,
   output i2cms_pkg::cq_head_type head
);

   i2cms_pkg::desc_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.desc  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("command queue count overflow");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (full && !do_pop) |=> full) else $error("full dropped without a pop");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (!head.valid && !do_push) |=> !head.valid)
      else $error("entry appeared without a push");

endmodule

// ===== rtl/i2cms_back.sv =====
`timescale 1ns / 1ps
module i2cms_back (
   input  logic                   clock,
   input  logic                   reset,
   input  i2cms_pkg::cq_head_type cq_head,
   output logic                   cq_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output i2cms_pkg::result_type  rsp
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_STOP  = 4'b0100,
      ST_BITS  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   i2cms_pkg::cmd_type  cmd_ff, cmd_in;
   logic [7:0]          data_ff, data_in;
   logic [1:0]          ph_ff, ph_in;
   logic [2:0]          bit_ff, bit_in;
   logic                scl_ff, scl_in;
   logic                sda_ff, sda_in;

   i2cms_pkg::result_type oq_ff [2];
   logic       oq_wr_ff, oq_wr_in;
   logic       oq_rd_ff, oq_rd_in;
   logic [1:0] oq_count_ff, oq_count_in;

   logic       emit, do_pop, released, is_scl, level, last, load;
   logic [2:0] last_bit;
   i2cms_pkg::result_type res;
   state_type  load_state;

   assign released = (cmd_ff == i2cms_pkg::CMD_READ_BYTE) ||
                     (cmd_ff == i2cms_pkg::CMD_READ_ACK);
   assign last_bit = ((cmd_ff == i2cms_pkg::CMD_WRITE_BYTE) ||
                      (cmd_ff == i2cms_pkg::CMD_READ_BYTE)) ? 3'd7 : 3'd0;

   // one pin write per step
   always_comb begin
      is_scl = 1'b0;
      level  = 1'b1;
      last   = 1'b0;
      unique case (state_ff)
         ST_START: begin
            is_scl = ph_ff[0];
            level  = !ph_ff[1];
            last   = (ph_ff == 2'd3);
         end
         ST_STOP: begin
            is_scl = ph_ff[0];
            level  = (ph_ff != 2'd0);
            last   = (ph_ff == 2'd2);
         end
         ST_BITS: begin
            is_scl = (ph_ff != 2'd0);
            level  = (ph_ff == 2'd0) ? (released || data_ff[7]) : (ph_ff == 2'd1);
            last   = (ph_ff == 2'd2) && (bit_ff == last_bit);
         end
         default: begin
            is_scl = 1'b0;
         end
      endcase
   end

   assign emit      = (state_ff != ST_IDLE) && (oq_count_ff != 2'd2);
   assign load      = cq_head.valid && ((state_ff == ST_IDLE) || (emit && last));
   assign cq_pop    = load;
   assign res.scl   = is_scl ? level : scl_ff;
   assign res.sda   = is_scl ? sda_ff : level;
   assign res.last  = last;
   assign res.value = (last && released) ? data_ff : 8'h00;

   always_comb begin
      unique case (cq_head.desc.cmd)
         i2cms_pkg::CMD_START: load_state = ST_START;
         i2cms_pkg::CMD_STOP:  load_state = ST_STOP;
         default:              load_state = ST_BITS;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      data_in  = data_ff;
      ph_in    = ph_ff;
      bit_in   = bit_ff;
      scl_in   = emit ? res.scl : scl_ff;
      sda_in   = emit ? res.sda : sda_ff;
      priority if (load) begin
         state_in = load_state;
         cmd_in   = cq_head.desc.cmd;
         data_in  = cq_head.desc.data;
         ph_in    = 2'd0;
         bit_in   = 3'd0;
      end else if (emit && last) begin
         state_in = ST_IDLE;
      end else if (emit) begin
         if ((state_ff == ST_BITS) && (ph_ff == 2'd2)) begin
            ph_in  = released ? 2'd1 : 2'd0;
            bit_in = bit_ff + 3'd1;
            if (cmd_ff == i2cms_pkg::CMD_WRITE_BYTE) begin
               data_in = {data_ff[6:0], 1'b0};
            end
         end else begin
            ph_in = ph_ff + 2'd1;
         end
      end
   end

   // output queue, so a short rsp stall does not hold the sequencer; a full one does
   assign do_pop    = rsp_pop && (oq_count_ff != 2'd0);
   assign rsp_empty = (oq_count_ff == 2'd0);
   assign rsp       = oq_ff[oq_rd_ff];

   always_comb begin
      oq_wr_in    = emit ? ~oq_wr_ff : oq_wr_ff;
      oq_rd_in    = do_pop ? ~oq_rd_ff : oq_rd_ff;
      oq_count_in = oq_count_ff + {1'b0, emit} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         oq_wr_ff    <= 1'b0;
         oq_rd_ff    <= 1'b0;
         oq_count_ff <= 2'd0;
      end else begin
         state_ff    <= state_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_count_ff <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      data_ff <= data_in;
      ph_ff   <= ph_in;
      bit_ff  <= bit_in;
      if (emit) begin
         oq_ff[oq_wr_ff] <= res;
      end
   end

   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_count_ff != 2'd3) else $error("result queue overflow");
   a_bits_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BITS) |-> (ph_ff != 2'd3)) else $error("bad bit phase");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (emit && last && !cq_head.valid) |=> (state_ff == ST_IDLE))
      else $error("sequencer ran past last step");
   a_pins_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> ($stable(scl_ff) && $stable(sda_ff)))
      else $error("pins moved while idle");

endmodule

// ===== rtl/i2c_master_bit_sequencer.sv =====
`timescale 1ns / 1ps
// channel  beat                                   accept
// req      command, data_byte, ack_bit, line_bits push && !full
// rsp      scl_level, sda_level, read_value, last  pop && !empty
//
// One pin write per cycle from the back-end sequencer while the result queue
// has room. A command gives 4 (start), 3 (stop, send ack, read ack), 24 (write
// byte) or 17 (read byte) beats, none for an idle load. Codes 6 and 7 give no beats.
// Reset is synchronous: both pins return to 1, both queues empty.
// A two-entry command queue takes new commands while one is in progress;
// a two-entry result queue absorbs short rsp stalls, a full one halts the sequencer.
module i2c_master_bit_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_ack_bit,
   input  logic [7:0] req_line_bits,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic [7:0] rsp_read_value,
   output logic       rsp_last_step
);

   logic                   desc_valid;
   i2cms_pkg::desc_type    desc;
   i2cms_pkg::cq_head_type cq_head;
   logic                   cq_pop;
   i2cms_pkg::result_type  rsp;

   i2cms_front u_front (
      .command    (req_command),
      .data_byte  (req_data_byte),
      .ack_bit    (req_ack_bit),
      .line_bits  (req_line_bits),
      .desc_valid (desc_valid),
      .desc       (desc)
   );

   i2cms_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && desc_valid),
      .push_desc (desc),
      .full      (req_full),
      .pop       (cq_pop),
      .head      (cq_head)
   );

   i2cms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cq_head   (cq_head),
      .cq_pop    (cq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_scl_level  = rsp.scl;
   assign rsp_sda_level  = rsp.sda;
   assign rsp_read_value = rsp.value;
   assign rsp_last_step  = rsp.last;

endmodule
